// ----- design/i2w_pkg.sv -----
// Shared types, token codes and constant-division factors for the word token core.
`default_nettype none

package i2w_pkg;

    // Number of three-digit groups (units, thousands, millions, billions)
    localparam int GROUPS = 4;
    // Token positions inside one group: digit, Hundred, tens, unit, multiplier
    localparam int SLOTS_PER_GROUP = 5;
    localparam int SLOTS = GROUPS * SLOTS_PER_GROUP;
    localparam int POS_W = $clog2(SLOTS + 1);

    localparam int SLOT_DIGIT   = 0;
    localparam int SLOT_HUNDRED = 1;
    localparam int SLOT_TENS    = 2;
    localparam int SLOT_UNIT    = 3;
    localparam int SLOT_MULT    = 4;

    // Token codes
    localparam logic [4:0] TOK_ZERO      = 5'd0;
    localparam logic [4:0] TOK_TEN       = 5'd10;
    localparam logic [4:0] TOK_TENS_BASE = 5'd18;
    localparam logic [4:0] TOK_HUNDRED   = 5'd28;
    localparam logic [4:0] TOK_THOUSAND  = 5'd29;
    localparam logic [4:0] TOK_MILLION   = 5'd30;
    localparam logic [4:0] TOK_BILLION   = 5'd31;

    // floor(v / 1000) = (v * RECIP_1000) >> RECIP_SHIFT, exact for any 31-bit v
    localparam int GROUP_BASE = 1000;
    localparam logic [31:0] RECIP_1000 = 32'd2199023256;
    localparam int RECIP_SHIFT = 41;

    // floor(g / 100) for g < 1000 and floor(r / 10) for r < 100
    localparam logic [15:0] DIV100_MUL = 16'd41;
    localparam int DIV100_SHIFT = 12;
    localparam logic [15:0] DIV10_MUL = 16'd205;
    localparam int DIV10_SHIFT = 11;

    typedef struct packed {
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] unit;
    } digits_t;

    // grp[0] is the units group, grp[3] the billions group
    typedef struct packed {
        digits_t [GROUPS-1:0] grp;
    } entry_t;

    function automatic logic [4:0] mult_tok(input logic [1:0] grp_idx);
        logic [4:0] tok;
        case (grp_idx)
            2'd1:    tok = TOK_THOUSAND;
            2'd2:    tok = TOK_MILLION;
            2'd3:    tok = TOK_BILLION;
            default: tok = TOK_ZERO;
        endcase
        return tok;
    endfunction

endpackage

`default_nettype wire

// ----- design/i2w_front.sv -----
// Front pipeline: splits a value into base-1000 groups and each group into decimal digits.
`default_nettype none

module i2w_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    output logic                      item_ready,
    input  wire logic [30:0]          value,
    output logic                      push_valid,
    input  wire logic                 push_ready,
    output i2w_pkg::entry_t           push_data
);

    localparam int STAGES = 8;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic              advance;

    // Stage 1: first quotient by 1000
    logic [62:0] s1_prod;
    logic [21:0] s1_q_reg, s1_q_next;
    logic [30:0] s1_v_reg;
    // Stage 2: units group
    logic [30:0] s2_rem;
    logic [9:0]  s2_g0_reg, s2_g0_next;
    logic [21:0] s2_v_reg;
    // Stage 3: second quotient by 1000
    logic [53:0] s3_prod;
    logic [11:0] s3_q_reg, s3_q_next;
    logic [21:0] s3_v_reg;
    logic [9:0]  s3_g0_reg;
    // Stage 4: thousands group
    logic [21:0] s4_rem;
    logic [9:0]  s4_g1_reg, s4_g1_next;
    logic [11:0] s4_v_reg;
    logic [9:0]  s4_g0_reg;
    // Stage 5: millions and billions groups
    logic [1:0]  s5_g3;
    logic [11:0] s5_rem;
    logic [i2w_pkg::GROUPS-1:0][9:0] s5_grp_reg, s5_grp_next;
    // Stage 6..8: digit split per group lane
    logic [i2w_pkg::GROUPS-1:0][15:0] s6_prod;
    logic [i2w_pkg::GROUPS-1:0][3:0]  s6_h_next, s6_h_reg;
    logic [i2w_pkg::GROUPS-1:0][9:0]  s6_grp_reg;
    logic [i2w_pkg::GROUPS-1:0][6:0]  s7_r_next, s7_r_reg;
    logic [i2w_pkg::GROUPS-1:0][3:0]  s7_h_reg;
    logic [i2w_pkg::GROUPS-1:0][15:0] s8_prod;
    logic [i2w_pkg::GROUPS-1:0][3:0]  s8_t_next, s8_t_reg;
    logic [i2w_pkg::GROUPS-1:0][6:0]  s8_r_reg;
    logic [i2w_pkg::GROUPS-1:0][3:0]  s8_h_reg;

    // The whole pipeline moves together; hold when the last stage cannot transfer
    assign advance    = !vld_reg[STAGES-1] || push_ready;
    assign item_ready = advance;
    assign push_valid = vld_reg[STAGES-1];

    always_comb
    begin
        vld_next = vld_reg;
        if (advance)
        begin
            vld_next = {vld_reg[STAGES-2:0], item_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s1_prod   = value * i2w_pkg::RECIP_1000;
    assign s1_q_next = s1_prod[62:i2w_pkg::RECIP_SHIFT];

    assign s2_rem     = s1_v_reg - 31'(s1_q_reg) * 31'(i2w_pkg::GROUP_BASE);
    assign s2_g0_next = s2_rem[9:0];

    assign s3_prod   = s2_v_reg * i2w_pkg::RECIP_1000;
    assign s3_q_next = s3_prod[52:i2w_pkg::RECIP_SHIFT];

    assign s4_rem     = s3_v_reg - 22'(s3_q_reg) * 22'(i2w_pkg::GROUP_BASE);
    assign s4_g1_next = s4_rem[9:0];

    // What remains is below 2148, so the last division is two compares
    always_comb
    begin
        if (s4_v_reg >= 12'(2 * i2w_pkg::GROUP_BASE))
        begin
            s5_g3  = 2'd2;
            s5_rem = s4_v_reg - 12'(2 * i2w_pkg::GROUP_BASE);
        end
        else if (s4_v_reg >= 12'(i2w_pkg::GROUP_BASE))
        begin
            s5_g3  = 2'd1;
            s5_rem = s4_v_reg - 12'(i2w_pkg::GROUP_BASE);
        end
        else
        begin
            s5_g3  = 2'd0;
            s5_rem = s4_v_reg;
        end
        s5_grp_next[0] = s4_g0_reg;
        s5_grp_next[1] = s4_g1_reg;
        s5_grp_next[2] = s5_rem[9:0];
        s5_grp_next[3] = 10'(s5_g3);
    end

    always_comb
    begin
        for (int k = 0; k < i2w_pkg::GROUPS; k++)
        begin
            s6_prod[k]   = 16'(s5_grp_reg[k]) * i2w_pkg::DIV100_MUL;
            s6_h_next[k] = 4'(s6_prod[k] >> i2w_pkg::DIV100_SHIFT);
            s7_r_next[k] = 7'(s6_grp_reg[k] - 10'(s6_h_reg[k]) * 10'd100);
            s8_prod[k]   = 16'(s7_r_reg[k]) * i2w_pkg::DIV10_MUL;
            s8_t_next[k] = 4'(s8_prod[k] >> i2w_pkg::DIV10_SHIFT);
            push_data.grp[k].hund = s8_h_reg[k];
            push_data.grp[k].tens = s8_t_reg[k];
            push_data.grp[k].unit = 4'(s8_r_reg[k] - 7'(s8_t_reg[k]) * 7'd10);
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_q_reg   <= s1_q_next;
            s1_v_reg   <= value;
            s2_g0_reg  <= s2_g0_next;
            s2_v_reg   <= s1_q_reg;
            s3_q_reg   <= s3_q_next;
            s3_v_reg   <= s2_v_reg;
            s3_g0_reg  <= s2_g0_reg;
            s4_g1_reg  <= s4_g1_next;
            s4_v_reg   <= s3_q_reg;
            s4_g0_reg  <= s3_g0_reg;
            s5_grp_reg <= s5_grp_next;
            s6_h_reg   <= s6_h_next;
            s6_grp_reg <= s5_grp_reg;
            s7_r_reg   <= s7_r_next;
            s7_h_reg   <= s6_h_reg;
            s8_t_reg   <= s8_t_next;
            s8_r_reg   <= s7_r_reg;
            s8_h_reg   <= s7_h_reg;
        end
    end

endmodule

`default_nettype wire

// ----- design/i2w_queue.sv -----
// Small FIFO of digit entries between the front pipeline and the token sequencer.
`default_nettype none

module i2w_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire i2w_pkg::entry_t  push_data,
    output logic                  head_valid,
    input  wire logic             pop,
    output i2w_pkg::entry_t       head_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    i2w_pkg::entry_t slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- design/i2w_back.sv -----
// Token sequencer: walks the token positions of the head entry and emits one token per transfer.
`default_nettype none

module i2w_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             head_valid,
    input  wire i2w_pkg::entry_t  head_data,
    output logic                  pop,
    output logic                  token_valid,
    input  wire logic             token_ready,
    output logic [4:0]            word,
    output logic                  last
);

    localparam int NS = i2w_pkg::SLOTS;
    localparam int PW = i2w_pkg::POS_W;

    logic [NS-1:0]      slot_vld;
    logic [NS-1:0][4:0] slot_word;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [PW-1:0]      pick;
    logic               found;
    logic               more;
    logic               emit;
    logic               valid_reg, valid_next;
    logic [4:0]         word_reg, word_next;
    logic               last_reg, last_next;

    // Lay out the possible tokens of all groups, billions first
    always_comb
    begin
        int base;
        logic nz;
        slot_vld  = '0;
        slot_word = '0;
        for (int k = 0; k < i2w_pkg::GROUPS; k++)
        begin
            base = (i2w_pkg::GROUPS - 1 - k) * i2w_pkg::SLOTS_PER_GROUP;
            nz   = (head_data.grp[k] != '0);

            slot_vld[base + i2w_pkg::SLOT_DIGIT]    = (head_data.grp[k].hund != '0);
            slot_word[base + i2w_pkg::SLOT_DIGIT]   = 5'(head_data.grp[k].hund);
            slot_vld[base + i2w_pkg::SLOT_HUNDRED]  = (head_data.grp[k].hund != '0);
            slot_word[base + i2w_pkg::SLOT_HUNDRED] = i2w_pkg::TOK_HUNDRED;

            slot_vld[base + i2w_pkg::SLOT_TENS]  = (head_data.grp[k].tens >= 4'd2);
            slot_word[base + i2w_pkg::SLOT_TENS] =
                i2w_pkg::TOK_TENS_BASE + 5'(head_data.grp[k].tens);

            // Ten to nineteen is one word
            if (head_data.grp[k].tens == 4'd1)
            begin
                slot_vld[base + i2w_pkg::SLOT_UNIT]  = 1'b1;
                slot_word[base + i2w_pkg::SLOT_UNIT] =
                    i2w_pkg::TOK_TEN + 5'(head_data.grp[k].unit);
            end
            else
            begin
                slot_vld[base + i2w_pkg::SLOT_UNIT]  = (head_data.grp[k].unit != '0);
                slot_word[base + i2w_pkg::SLOT_UNIT] = 5'(head_data.grp[k].unit);
            end

            slot_vld[base + i2w_pkg::SLOT_MULT]  = nz && (k > 0);
            slot_word[base + i2w_pkg::SLOT_MULT] = i2w_pkg::mult_tok(2'(k));
        end
    end

    // First live position at or past the cursor, and whether any follows it
    always_comb
    begin
        pick  = '0;
        found = 1'b0;
        more  = 1'b0;
        for (int p = 0; p < NS; p++)
        begin
            if (!found && slot_vld[p] && (PW'(p) >= pos_reg))
            begin
                pick  = PW'(p);
                found = 1'b1;
            end
        end
        for (int p = 0; p < NS; p++)
        begin
            if (slot_vld[p] && (PW'(p) > pick))
            begin
                more = 1'b1;
            end
        end
    end

    assign emit = head_valid && (!valid_reg || token_ready);

    always_comb
    begin
        // An all-zero entry spells Zero
        word_next  = found ? slot_word[pick] : i2w_pkg::TOK_ZERO;
        last_next  = !found || !more;
        pop        = emit && last_next;
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (emit)
        begin
            pos_next   = last_next ? '0 : pick + 1'b1;
            valid_next = 1'b1;
        end
        else if (token_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            word_reg <= word_next;
            last_reg <= last_next;
        end
    end

    assign token_valid = valid_reg;
    assign word        = word_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ----- design/integer_to_word_tokens_core.sv -----
// Top level of the integer to English word token core.
`default_nettype none

// Spells a 31-bit unsigned value as English word tokens, billions group first, one token per
// transfer on the token channel, with last set on the final token of each value. An eight-stage
// front pipeline splits each value into base-1000 groups and decimal digits and accepts a new
// value every cycle while the queue has room; a queue of QUEUE_DEPTH entries feeds the token
// sequencer, which emits one token per cycle from its output register unless the queue is empty
// or the token channel is held. A value spells as 1 to 16 tokens, so the sequencer sets the
// sustained rate. A value crosses the eight front stages, the queue and the output register.
module integer_to_word_tokens_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [30:0] value,
    output logic             token_valid,
    input  wire logic        token_ready,
    output logic [4:0]       word,
    output logic             last
);

    logic            push_valid;
    logic            push_ready;
    i2w_pkg::entry_t push_data;
    logic            head_valid;
    logic            pop;
    i2w_pkg::entry_t head_data;

    i2w_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    i2w_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .head_valid (head_valid),
        .pop        (pop),
        .head_data  (head_data)
    );

    i2w_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_data   (head_data),
        .pop         (pop),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .word        (word),
        .last        (last)
    );

    // Zero is only ever spelled on its own
    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && (word == i2w_pkg::TOK_ZERO)) |-> last)
        else $error("Zero token without last flag");

    // A waiting entry with a free output register always yields a token
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && (!token_valid || token_ready)) |=> token_valid)
        else $error("token sequencer failed to advance");

    // A full queue must hold the front pipeline and the value channel
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_valid && !push_ready) |-> !item_ready)
        else $error("value taken while front pipeline is held");

endmodule

`default_nettype wire
